FILE: rtl/asc_pkg.sv
package asc_pkg;

    // Input function codes
    localparam logic [3:0] FUNC_SMOKE     = 4'd0;
    localparam logic [3:0] FUNC_CO        = 4'd1;
    localparam logic [3:0] FUNC_BATTERY   = 4'd2;
    localparam logic [3:0] FUNC_MUTE      = 4'd3;
    localparam logic [3:0] FUNC_TEST      = 4'd4;
    localparam logic [3:0] FUNC_FAULT     = 4'd5;
    localparam logic [3:0] FUNC_EOS       = 4'd6;
    localparam logic [3:0] FUNC_IC_SMOKE  = 4'd7;
    localparam logic [3:0] FUNC_IC_CO     = 4'd8;
    localparam logic [3:0] FUNC_CONTAM    = 4'd9;
    localparam logic [3:0] FUNC_SENS      = 4'd10;
    localparam logic [3:0] FUNC_SELFTEST  = 4'd11;
    localparam logic [3:0] FUNC_EVALUATE  = 4'd12;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_BUSY    = 2'd2;

    // Event codes
    localparam logic [3:0] EV_NONE       = 4'd0;
    localparam logic [3:0] EV_SMOKE      = 4'd1;
    localparam logic [3:0] EV_CO         = 4'd2;
    localparam logic [3:0] EV_BATTERY    = 4'd3;
    localparam logic [3:0] EV_FAULT      = 4'd4;
    localparam logic [3:0] EV_EOS        = 4'd5;
    localparam logic [3:0] EV_TEST_DONE  = 4'd6;
    localparam logic [3:0] EV_MUTED      = 4'd7;
    localparam logic [3:0] EV_MUTE_ENDED = 4'd8;
    localparam logic [3:0] EV_IC_SMOKE   = 4'd9;
    localparam logic [3:0] EV_IC_CO      = 4'd10;
    localparam logic [3:0] EV_ALL_CLEAR  = 4'd11;

    // Expressed state codes
    localparam logic [3:0] EXPR_NORMAL   = 4'd0;
    localparam logic [3:0] EXPR_SMOKE    = 4'd1;
    localparam logic [3:0] EXPR_CO       = 4'd2;
    localparam logic [3:0] EXPR_BATTERY  = 4'd3;
    localparam logic [3:0] EXPR_TESTING  = 4'd4;
    localparam logic [3:0] EXPR_FAULT    = 4'd5;
    localparam logic [3:0] EXPR_EOS      = 4'd6;
    localparam logic [3:0] EXPR_IC_SMOKE = 4'd7;
    localparam logic [3:0] EXPR_IC_CO    = 4'd8;

    // Alarm levels
    localparam logic [1:0] LVL_NORMAL   = 2'd0;
    localparam logic [1:0] LVL_WARNING  = 2'd1;
    localparam logic [1:0] LVL_CRITICAL = 2'd2;

    localparam logic [1:0] SENS_STANDARD = 2'd1;
    localparam logic [31:0] PRIO_RESET   = 32'h3645_8271;

    // Register addresses
    localparam logic [2:0] ADDR_PRIORITY = 3'd0;

    typedef struct packed {
        logic [1:0] smoke;
        logic [1:0] co;
        logic [1:0] battery;
        logic [1:0] ic_smoke;
        logic [1:0] ic_co;
        logic       mute;
        logic       testing;
        logic       fault;
        logic       eos;
        logic [1:0] contam;
        logic [1:0] sens;
        logic [3:0] expressed;
    } t_state;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] first_event;
        logic [1:0] event_level;
        logic [3:0] second_event;
        logic       self_test_started;
    } t_result;

    localparam t_state STATE_RESET = '{
        smoke: LVL_NORMAL, co: LVL_NORMAL, battery: LVL_NORMAL,
        ic_smoke: LVL_NORMAL, ic_co: LVL_NORMAL,
        mute: 1'b0, testing: 1'b0, fault: 1'b0, eos: 1'b0,
        contam: 2'd0, sens: SENS_STANDARD, expressed: EXPR_NORMAL
    };

endpackage

FILE: rtl/asc_eval.sv
module asc_eval #(
    parameter int PRIORITY_SLOTS = 8
) (
    input  asc_pkg::t_state  i_state,
    input  logic [31:0]      i_priority,
    input  logic [3:0]       i_func,
    input  logic [1:0]       i_value,
    output asc_pkg::t_state  o_state,
    output asc_pkg::t_result o_result
);
    import asc_pkg::*;

    logic       any_critical;
    logic [1:0] alarm_cur;
    logic [3:0] alarm_event;
    logic [3:0] pick;
    logic [3:0] slot_code;

    // Source of a code is active
    function automatic logic source_active(input t_state s, input logic [3:0] code);
        logic act;
        act = 1'b0;
        case (code)
            EXPR_SMOKE:    act = (s.smoke != LVL_NORMAL);
            EXPR_CO:       act = (s.co != LVL_NORMAL);
            EXPR_BATTERY:  act = (s.battery != LVL_NORMAL);
            EXPR_TESTING:  act = s.testing;
            EXPR_FAULT:    act = s.fault;
            EXPR_EOS:      act = s.eos;
            EXPR_IC_SMOKE: act = (s.ic_smoke != LVL_NORMAL);
            EXPR_IC_CO:    act = (s.ic_co != LVL_NORMAL);
            default:       act = 1'b0;
        endcase
        return act;
    endfunction

    assign any_critical = (i_state.smoke == LVL_CRITICAL) || (i_state.co == LVL_CRITICAL) ||
                          (i_state.battery == LVL_CRITICAL) ||
                          (i_state.ic_smoke == LVL_CRITICAL) ||
                          (i_state.ic_co == LVL_CRITICAL);

    // Scan priority slots; lowest slot wins
    always_comb begin
        pick      = EXPR_NORMAL;
        slot_code = 4'd0;
        for (int i = PRIORITY_SLOTS - 1; i >= 0; i--) begin
            slot_code = i_priority[4*i +: 4];
            if (source_active(i_state, slot_code)) begin
                pick = slot_code;
            end
        end
    end

    // Select the alarm level addressed by the function
    always_comb begin
        alarm_cur   = i_state.smoke;
        alarm_event = EV_SMOKE;
        case (i_func)
            FUNC_CO: begin
                alarm_cur   = i_state.co;
                alarm_event = EV_CO;
            end
            FUNC_BATTERY: begin
                alarm_cur   = i_state.battery;
                alarm_event = EV_BATTERY;
            end
            FUNC_IC_SMOKE: begin
                alarm_cur   = i_state.ic_smoke;
                alarm_event = EV_IC_SMOKE;
            end
            FUNC_IC_CO: begin
                alarm_cur   = i_state.ic_co;
                alarm_event = EV_IC_CO;
            end
            default: begin
                alarm_cur   = i_state.smoke;
                alarm_event = EV_SMOKE;
            end
        endcase
    end

    // Apply one item to the state
    always_comb begin
        o_state  = i_state;
        o_result = '{status: ST_OK, first_event: EV_NONE, event_level: 2'd0,
                     second_event: EV_NONE, self_test_started: 1'b0};
        unique case (i_func) inside
            FUNC_SMOKE, FUNC_CO, FUNC_BATTERY, FUNC_IC_SMOKE, FUNC_IC_CO: begin
                if (i_value > LVL_CRITICAL) begin
                    o_result.status = ST_REFUSED;
                end else if (alarm_cur != i_value) begin
                    case (i_func)
                        FUNC_CO:       o_state.co       = i_value;
                        FUNC_BATTERY:  o_state.battery  = i_value;
                        FUNC_IC_SMOKE: o_state.ic_smoke = i_value;
                        FUNC_IC_CO:    o_state.ic_co    = i_value;
                        default:       o_state.smoke    = i_value;
                    endcase
                    if (i_value != LVL_NORMAL) begin
                        o_result.first_event = alarm_event;
                        o_result.event_level = i_value;
                    end
                    if (i_value == LVL_CRITICAL && i_state.mute) begin
                        o_state.mute          = 1'b0;
                        o_result.second_event = EV_MUTE_ENDED;
                    end
                end
            end
            FUNC_MUTE: begin
                if (i_value[1]) begin
                    o_result.status = ST_REFUSED;
                end else if (i_state.mute != i_value[0]) begin
                    if (i_value[0] && any_critical) begin
                        o_result.status = ST_REFUSED;
                    end else begin
                        o_state.mute         = i_value[0];
                        o_result.first_event = i_value[0] ? EV_MUTED : EV_MUTE_ENDED;
                    end
                end
            end
            FUNC_TEST: begin
                if (i_value[1]) begin
                    o_result.status = ST_REFUSED;
                end else if (i_state.testing != i_value[0]) begin
                    o_state.testing = i_value[0];
                    if (!i_value[0]) o_result.first_event = EV_TEST_DONE;
                end
            end
            FUNC_FAULT: begin
                if (i_value[1]) begin
                    o_result.status = ST_REFUSED;
                end else if (i_state.fault != i_value[0]) begin
                    o_state.fault = i_value[0];
                    if (i_value[0]) o_result.first_event = EV_FAULT;
                end
            end
            FUNC_EOS: begin
                if (i_value[1]) begin
                    o_result.status = ST_REFUSED;
                end else if (i_state.eos != i_value[0]) begin
                    o_state.eos = i_value[0];
                    if (i_value[0]) o_result.first_event = EV_EOS;
                end
            end
            FUNC_CONTAM: begin
                o_state.contam = i_value;
            end
            FUNC_SENS: begin
                if (i_value == 2'd3) begin
                    o_result.status = ST_REFUSED;
                end else begin
                    o_state.sens = i_value;
                end
            end
            FUNC_SELFTEST: begin
                case (i_state.expressed) inside
                    EXPR_SMOKE, EXPR_CO, EXPR_TESTING, EXPR_IC_SMOKE, EXPR_IC_CO: begin
                        o_result.status = ST_BUSY;
                    end
                    default: begin
                        o_state.testing            = 1'b1;
                        o_state.expressed          = EXPR_TESTING;
                        o_result.self_test_started = 1'b1;
                    end
                endcase
            end
            FUNC_EVALUATE: begin
                if (pick != i_state.expressed) begin
                    o_state.expressed = pick;
                    if (pick == EXPR_NORMAL) o_result.first_event = EV_ALL_CLEAR;
                end
            end
            default: begin
                o_result.status = ST_REFUSED;
            end
        endcase
    end

endmodule

FILE: rtl/alarm_state_controller_core.sv
// Alarm state controller core.
// An item accepted into the input register is applied to the state and its result is registered.
// Throughput: one item per cycle while the output is not stalled; the input and result registers
// form one stage around the state update, and the source state carries straight from item to item.
// Reset (synchronous, active low) clears all sources, sets sensitivity to standard and
// loads the priority register with 0x36458271.
module alarm_state_controller_core #(
    parameter int PRIORITY_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_func,
    input  logic [1:0]  i_value,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_first_event,
    output logic [1:0]  o_event_level,
    output logic [3:0]  o_second_event,
    output logic        o_self_test_started,
    output logic [3:0]  o_expressed_now,
    output logic        o_muted_now,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import asc_pkg::*;

    logic        r_in_valid;
    logic [3:0]  r_func;
    logic [1:0]  r_value;
    logic        r_out_valid;
    t_result     r_result;
    t_state      r_state;
    logic [31:0] r_priority;

    t_state      n_state;
    t_result     n_result;
    logic        out_free;
    logic        proc;

    asc_eval #(
        .PRIORITY_SLOTS(PRIORITY_SLOTS)
    ) u_eval (
        .i_state   (r_state),
        .i_priority(r_priority),
        .i_func    (r_func),
        .i_value   (r_value),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    // Handshake: the result register frees when empty or being taken
    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && !o_in_stall) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
    end

    // Advance state and capture the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else if (proc) begin
            r_out_valid <= 1'b1;
            r_state     <= n_state;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (proc) begin
            r_result <= n_result;
        end
    end

    // Priority register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_priority <= PRIO_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_PRIORITY) begin
            r_priority <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_PRIORITY) ? r_priority : 32'd0;

    // Drive result ports
    assign o_out_valid         = r_out_valid;
    assign o_status            = r_result.status;
    assign o_first_event       = r_result.first_event;
    assign o_event_level       = r_result.event_level;
    assign o_second_event      = r_result.second_event;
    assign o_self_test_started = r_result.self_test_started;
    assign o_expressed_now     = r_state.expressed;
    assign o_muted_now         = r_state.mute;

endmodule

FILE: dv/tb_top.sv
module tb_top;
    import asc_pkg::*;

    localparam int          PRIORITY_SLOTS = 8;
    localparam int          RX_HOLD_CYCLES = 200;
    localparam int          DRAIN_CYCLES   = 6;
    localparam int          TIMEOUT_TIME   = 4_000_000;
    localparam logic [3:0]  FUNC_BAD_LO    = 4'd13;
    localparam logic [3:0]  FUNC_BAD_HI    = 4'd15;
    localparam logic [1:0]  FLAG_MAX       = 2'd1;
    localparam logic [1:0]  SENS_LOW       = 2'd2;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] first_event;
        logic [1:0] event_level;
        logic [3:0] second_event;
        logic       self_test_started;
        logic [3:0] expressed_now;
        logic       muted_now;
    } t_alarm_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [3:0]  i_func;
    logic [1:0]  i_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic [3:0]  o_first_event;
    logic [1:0]  o_event_level;
    logic [3:0]  o_second_event;
    logic        o_self_test_started;
    logic [3:0]  o_expressed_now;
    logic        o_muted_now;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Alarm state mirror and the results still owed by the block
    t_state        alarm_model;
    logic [31:0]   priority_model;
    t_alarm_result pending_results[$];
    int            mismatch_count;
    bit            tx_idle_on;
    bit            rx_idle_on;
    bit            hold_rx_req;

    alarm_state_controller_core #(
        .PRIORITY_SLOTS(PRIORITY_SLOTS)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_func             (i_func),
        .i_value            (i_value),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_first_event      (o_first_event),
        .o_event_level      (o_event_level),
        .o_second_event     (o_second_event),
        .o_self_test_started(o_self_test_started),
        .o_expressed_now    (o_expressed_now),
        .o_muted_now        (o_muted_now),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Alarm state predictor
    // ------------------------------------------------------------------
    function automatic bit any_critical();
        return alarm_model.smoke == LVL_CRITICAL || alarm_model.co == LVL_CRITICAL ||
               alarm_model.battery == LVL_CRITICAL || alarm_model.ic_smoke == LVL_CRITICAL ||
               alarm_model.ic_co == LVL_CRITICAL;
    endfunction

    function automatic bit source_active(input logic [3:0] code);
        case (code)
            EXPR_SMOKE:    return alarm_model.smoke != LVL_NORMAL;
            EXPR_CO:       return alarm_model.co != LVL_NORMAL;
            EXPR_BATTERY:  return alarm_model.battery != LVL_NORMAL;
            EXPR_TESTING:  return alarm_model.testing;
            EXPR_FAULT:    return alarm_model.fault;
            EXPR_EOS:      return alarm_model.eos;
            EXPR_IC_SMOKE: return alarm_model.ic_smoke != LVL_NORMAL;
            EXPR_IC_CO:    return alarm_model.ic_co != LVL_NORMAL;
            default:       return 1'b0;
        endcase
    endfunction

    // Walk the priority nibbles, lowest first; skip codes that name no source
    function automatic logic [3:0] pick_expressed();
        logic [3:0] code;
        logic [3:0] pick;
        bit         found;
        pick  = EXPR_NORMAL;
        found = 1'b0;
        for (int slot = 0; slot < PRIORITY_SLOTS; slot++) begin
            code = priority_model[4*slot +: 4];
            if (!found && code >= EXPR_SMOKE && code <= EXPR_IC_CO && source_active(code)) begin
                pick  = code;
                found = 1'b1;
            end
        end
        return pick;
    endfunction

    function automatic void write_alarm_level(inout logic [1:0] level, input logic [1:0] v,
                                              input logic [3:0] ev, inout t_alarm_result res);
        if (v > LVL_CRITICAL) begin
            res.status = ST_REFUSED;
        end else if (level != v) begin
            level = v;
            if (v != LVL_NORMAL) begin
                res.first_event = ev;
                res.event_level = v;
            end
            // A new critical alarm overrides the mute
            if (v == LVL_CRITICAL && alarm_model.mute) begin
                alarm_model.mute  = 1'b0;
                res.second_event  = EV_MUTE_ENDED;
            end
        end
    endfunction

    function automatic t_alarm_result apply_alarm_item(input logic [3:0] f, input logic [1:0] v);
        t_alarm_result res;
        logic [3:0]    pick;
        logic [3:0]    cur;
        res = '0;
        case (f)
            FUNC_SMOKE:    write_alarm_level(alarm_model.smoke, v, EV_SMOKE, res);
            FUNC_CO:       write_alarm_level(alarm_model.co, v, EV_CO, res);
            FUNC_BATTERY:  write_alarm_level(alarm_model.battery, v, EV_BATTERY, res);
            FUNC_IC_SMOKE: write_alarm_level(alarm_model.ic_smoke, v, EV_IC_SMOKE, res);
            FUNC_IC_CO:    write_alarm_level(alarm_model.ic_co, v, EV_IC_CO, res);
            FUNC_MUTE: begin
                if (v > FLAG_MAX) begin
                    res.status = ST_REFUSED;
                end else if (alarm_model.mute != v[0]) begin
                    if (v[0] && any_critical()) begin
                        res.status = ST_REFUSED;
                    end else begin
                        alarm_model.mute = v[0];
                        res.first_event  = v[0] ? EV_MUTED : EV_MUTE_ENDED;
                    end
                end
            end
            FUNC_TEST: begin
                if (v > FLAG_MAX) begin
                    res.status = ST_REFUSED;
                end else if (alarm_model.testing != v[0]) begin
                    alarm_model.testing = v[0];
                    if (!v[0]) res.first_event = EV_TEST_DONE;
                end
            end
            FUNC_FAULT: begin
                if (v > FLAG_MAX) begin
                    res.status = ST_REFUSED;
                end else if (alarm_model.fault != v[0]) begin
                    alarm_model.fault = v[0];
                    if (v[0]) res.first_event = EV_FAULT;
                end
            end
            FUNC_EOS: begin
                if (v > FLAG_MAX) begin
                    res.status = ST_REFUSED;
                end else if (alarm_model.eos != v[0]) begin
                    alarm_model.eos = v[0];
                    if (v[0]) res.first_event = EV_EOS;
                end
            end
            FUNC_CONTAM: alarm_model.contam = v;
            FUNC_SENS: begin
                if (v > SENS_LOW) res.status = ST_REFUSED;
                else alarm_model.sens = v;
            end
            FUNC_SELFTEST: begin
                cur = alarm_model.expressed;
                if (cur == EXPR_SMOKE || cur == EXPR_CO || cur == EXPR_TESTING ||
                    cur == EXPR_IC_SMOKE || cur == EXPR_IC_CO) begin
                    res.status = ST_BUSY;
                end else begin
                    alarm_model.testing   = 1'b1;
                    alarm_model.expressed = EXPR_TESTING;
                    res.self_test_started = 1'b1;
                end
            end
            FUNC_EVALUATE: begin
                pick = pick_expressed();
                if (pick != alarm_model.expressed) begin
                    alarm_model.expressed = pick;
                    if (pick == EXPR_NORMAL) res.first_event = EV_ALL_CLEAR;
                end
            end
            default: res.status = ST_REFUSED;
        endcase
        res.expressed_now = alarm_model.expressed;
        res.muted_now     = alarm_model.mute;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mostly short gaps, a few long ones
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int tx_gap();
        if (!tx_idle_on || $urandom_range(0, 99) < 60) return 0;
        return gap_length();
    endfunction

    task automatic send_item(input logic [3:0] f, input logic [1:0] v);
        int gap;
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_value    <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(apply_alarm_item(f, v));
        gap = tx_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Mostly legal writes and frequent evaluations, with some refused noise
    function automatic void pick_random_item(output logic [3:0] f, output logic [1:0] v);
        int r;
        r = $urandom_range(0, 99);
        if (r < 16)      f = FUNC_EVALUATE;
        else if (r < 24) f = FUNC_SELFTEST;
        else if (r < 27) f = 4'($urandom_range(FUNC_BAD_LO, FUNC_BAD_HI));
        else             f = 4'($urandom_range(FUNC_SMOKE, FUNC_SENS));
        if ($urandom_range(0, 9) == 0) begin
            v = 2'($urandom_range(0, 3));
        end else begin
            case (f) inside
                FUNC_MUTE, FUNC_TEST, FUNC_FAULT, FUNC_EOS: v = 2'($urandom_range(0, 1));
                FUNC_CONTAM, FUNC_SELFTEST, FUNC_EVALUATE:  v = 2'($urandom_range(0, 3));
                default:                                    v = 2'($urandom_range(0, 2));
            endcase
        end
    endfunction

    task automatic send_random_items(input int count);
        logic [3:0] f;
        logic [1:0] v;
        repeat (count) begin
            pick_random_item(f, v);
            send_item(f, v);
        end
    endtask

    // Drop valid and wait until every owed result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_priority_reg();
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= ADDR_PRIORITY;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== priority_model) report_mismatch("priority readback", prdata, priority_model);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_priority(input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_PRIORITY;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        priority_model = data;
        psel    <= 1'b0;
        penable <= 1'b0;
        // Return to idle between the write and the readback
        @(posedge i_clk);
        check_priority_reg();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        check_priority_reg();
        send_item(FUNC_EVALUATE, 2'd0);
        drain_results();
    endtask

    task automatic test_directed_cases();
        send_item(FUNC_SMOKE, 2'd3);
        send_item(FUNC_MUTE, 2'd1);
        send_item(FUNC_MUTE, 2'd1);
        send_item(FUNC_SMOKE, LVL_WARNING);
        // Critical while muted: unmute and report the mute ending
        send_item(FUNC_IC_CO, LVL_CRITICAL);
        send_item(FUNC_IC_CO, LVL_CRITICAL);
        send_item(FUNC_MUTE, 2'd1);
        send_item(FUNC_MUTE, 2'd2);
        send_item(FUNC_EVALUATE, 2'd3);
        send_item(FUNC_SELFTEST, 2'd0);
        send_item(FUNC_SMOKE, LVL_NORMAL);
        send_item(FUNC_IC_CO, LVL_NORMAL);
        send_item(FUNC_CO, LVL_WARNING);
        send_item(FUNC_BATTERY, LVL_CRITICAL);
        send_item(FUNC_FAULT, 2'd2);
        send_item(FUNC_FAULT, 2'd1);
        send_item(FUNC_EOS, 2'd1);
        send_item(FUNC_IC_SMOKE, LVL_WARNING);
        send_item(FUNC_CONTAM, 2'd3);
        send_item(FUNC_SENS, 2'd3);
        send_item(FUNC_SENS, 2'd0);
        send_item(FUNC_TEST, 2'd3);
        send_item(FUNC_BAD_LO, 2'd0);
        send_item(FUNC_BAD_HI, 2'd3);
        // Clear every source, then evaluate back to normal
        send_item(FUNC_CO, LVL_NORMAL);
        send_item(FUNC_BATTERY, LVL_NORMAL);
        send_item(FUNC_FAULT, 2'd0);
        send_item(FUNC_EOS, 2'd0);
        send_item(FUNC_IC_SMOKE, LVL_NORMAL);
        send_item(FUNC_EVALUATE, 2'd1);
        send_item(FUNC_SELFTEST, 2'd3);
        send_item(FUNC_SELFTEST, 2'd0);
        send_item(FUNC_TEST, 2'd0);
        drain_results();
    endtask

    task automatic test_priority_settings();
        logic [31:0] order;
        logic [31:0] settings[$];
        settings = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8765_4321, 32'h1234_5678,
                     32'h9A0B_4C5D, 32'h0000_0000, 32'h0000_0000};
        // Two random orders: one of mostly valid codes, one fully random
        for (int slot = 0; slot < PRIORITY_SLOTS; slot++)
            order[4*slot +: 4] = 4'($urandom_range(0, 9));
        settings[5] = order;
        settings[6] = $urandom;
        foreach (settings[idx]) begin
            drain_results();
            write_priority(settings[idx]);
            send_random_items(60);
        end
        drain_results();
        write_priority(PRIO_RESET);
    endtask

    task automatic test_random_traffic();
        for (int blk = 0; blk < 14; blk++) begin
            // Randomly pick stretches with and without idling
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            send_random_items(100);
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        drain_results();
    endtask

    task automatic test_input_backpressure();
        tx_idle_on  = 1'b0;
        hold_rx_req = 1'b1;
        send_random_items(60);
        tx_idle_on  = 1'b1;
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Receiver stall and result checking
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        int hold_cnt;
        stall_left  = 0;
        hold_cnt    = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_rx_req) begin
                i_out_stall <= 1'b1;
                hold_cnt++;
                if (hold_cnt >= RX_HOLD_CYCLES) begin
                    hold_rx_req = 1'b0;
                    hold_cnt    = 0;
                end
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
                i_out_stall <= 1'b1;
                stall_left  = gap_length() - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_alarm_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", 32'd1, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_first_event !== want.first_event)
                    report_mismatch("first_event", 32'(o_first_event),
                                    32'(want.first_event));
                if (o_event_level !== want.event_level)
                    report_mismatch("event_level", 32'(o_event_level),
                                    32'(want.event_level));
                if (o_second_event !== want.second_event)
                    report_mismatch("second_event", 32'(o_second_event),
                                    32'(want.second_event));
                if (o_self_test_started !== want.self_test_started)
                    report_mismatch("self_test_started", 32'(o_self_test_started),
                                    32'(want.self_test_started));
                if (o_expressed_now !== want.expressed_now)
                    report_mismatch("expressed_now", 32'(o_expressed_now),
                                    32'(want.expressed_now));
                if (o_muted_now !== want.muted_now)
                    report_mismatch("muted_now", 32'(o_muted_now), 32'(want.muted_now));
            end
        end
    end

    // Watchdog
    initial begin
        #(TIMEOUT_TIME);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        alarm_model    = STATE_RESET;
        priority_model = PRIO_RESET;
        mismatch_count = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        hold_rx_req    = 1'b0;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_func         <= FUNC_EVALUATE;
        i_value        <= 2'd0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= ADDR_PRIORITY;
        pwdata         <= 32'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_directed_cases();
        test_priority_settings();
        test_random_traffic();
        test_input_backpressure();
        drain_results();

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
